// ===== design/framed_command_responder_defines.svh =====
// assertion macros for the framed command responder
`ifndef FRAMED_COMMAND_RESPONDER_DEFINES_SVH
`define FRAMED_COMMAND_RESPONDER_DEFINES_SVH

`ifndef SYNTHESIS

`define FCR_ASSERT_IMPLIES(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

`define FCR_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`else

`define FCR_ASSERT_IMPLIES(lbl, ck, rn, ante, cons, msg)

`define FCR_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)

`endif

`endif

// ===== design/fcr_pkg.sv =====
// shared constants, types and response formatting for the framed command responder
package fcr_pkg;

	localparam int FRAME_DEPTH_DEF = 16;

	localparam logic [15:0] JUMP_LIMIT_RST = 16'd16;
	localparam logic [15:0] TEMP_INVALID   = 16'h8000;
	localparam logic [15:0] ERASED         = 16'hFFFF;

	localparam logic [7:0] BYTE_HEAD    = 8'hFD;
	localparam logic [7:0] BYTE_END     = 8'hFE;
	localparam logic [7:0] CMD_STATUS   = 8'h00;
	localparam logic [7:0] CMD_SETPOINT = 8'h11;
	localparam logic [7:0] CMD_LINE     = 8'h21;
	localparam logic [7:0] CMD_DUMP     = 8'hF0;

	localparam logic [3:0] LAST_STATUS = 4'd4;
	localparam logic [3:0] LAST_DUMP   = 4'd12;

	localparam logic OP_BYTE = 1'b0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_DECODE,
		ST_SEND
	} fcr_state_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] tx_byte;
		logic       last_byte;
	} fcr_push_t;

	function automatic logic [7:0] resp_byte(
		input logic        dump,
		input logic [3:0]  k,
		input logic [15:0] temp,
		input logic [15:0] line,
		input logic [15:0] setp,
		input logic [15:0] ltime,
		input logic [15:0] ttime
	);
		logic [7:0] b;
		b = BYTE_END;
		if (!dump) begin
			case (k)
				4'd0:    b = BYTE_HEAD;
				4'd1:    b = CMD_STATUS;
				4'd2:    b = temp[7:0];
				4'd3:    b = temp[15:8];
				default: b = BYTE_END;
			endcase
		end else begin
			case (k)
				4'd0:    b = BYTE_HEAD;
				4'd1:    b = CMD_DUMP;
				4'd2:    b = line[7:0];
				4'd3:    b = line[15:8];
				4'd4:    b = setp[7:0];
				4'd5:    b = setp[15:8];
				4'd6:    b = ltime[7:0];
				4'd7:    b = ltime[15:8];
				4'd8:    b = ttime[7:0];
				4'd9:    b = ttime[15:8];
				4'd10:   b = temp[7:0];
				4'd11:   b = temp[15:8];
				default: b = BYTE_END;
			endcase
		end
		return b;
	endfunction

endpackage

// ===== design/fcr_if.sv =====
// request and response channel interfaces
interface fcr_req_if;
	logic               valid;
	logic               ready;
	logic               opcode;
	logic [7:0]         rx_byte;
	logic signed [15:0] sample;

	modport source (output valid, opcode, rx_byte, sample, input ready);
	modport sink   (input valid, opcode, rx_byte, sample, output ready);
endinterface

interface fcr_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic       last_byte;

	modport source (output valid, tx_byte, last_byte, input ready);
	modport sink   (input valid, tx_byte, last_byte, output ready);
endinterface

// ===== design/fcr_ram.sv =====
// generic single-write, single-read ram with registered read data
module fcr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/fcr_seq.sv =====
// sequencer: frame store access, command decode, state registers and response beats
`include "framed_command_responder_defines.svh"

module fcr_seq #(
	parameter int FRAME_DEPTH = fcr_pkg::FRAME_DEPTH_DEF,
	localparam int AW         = $clog2(FRAME_DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	fcr_req_if.sink           req,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_data,
	output logic              ram_we,
	output logic [AW-1:0]     ram_waddr,
	output logic [7:0]        ram_wdata,
	output logic [AW-1:0]     ram_raddr,
	input  logic [7:0]        ram_rdata,
	output fcr_pkg::fcr_push_t push,
	input  logic              push_ready
);
	import fcr_pkg::*;

	fcr_state_t  state_q, state_d;
	logic [AW-1:0] wr_idx_q;
	logic [2:0]  cnt_q;
	logic [3:0]  k_q;
	logic        dump_q;
	logic [7:0]  hdr_q [4];
	logic [15:0] jump_limit_q;
	logic [15:0] temp_q;
	logic [15:0] line_q;
	logic [15:0] setp_q;
	logic [15:0] ltime_q;
	logic [15:0] ttime_q;

	logic        acc;
	logic        last;
	logic [15:0] word;
	logic signed [17:0] diff;
	logic signed [17:0] lim;
	logic        reject;

	assign acc  = req.valid && req.ready;
	assign word = {hdr_q[3], hdr_q[2]};
	assign last = (k_q == (dump_q ? LAST_DUMP : LAST_STATUS));

	assign diff   = $signed({{2{temp_q[15]}}, temp_q}) - $signed({{2{req.sample[15]}}, req.sample});
	assign lim    = $signed({2'b00, jump_limit_q});
	assign reject = (temp_q != TEMP_INVALID) && ((diff > lim) || ((diff + lim) < 18'sd0));

	assign ram_we    = acc && (req.opcode == OP_BYTE);
	assign ram_waddr = wr_idx_q;
	assign ram_wdata = req.rx_byte;
	assign ram_raddr = AW'(cnt_q[1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		req.ready      = 1'b0;
		push.valid     = 1'b0;
		push.tx_byte   = resp_byte(dump_q, k_q, temp_q, line_q, setp_q, ltime_q, ttime_q);
		push.last_byte = last;
		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid && req.opcode == OP_BYTE && req.rx_byte == BYTE_END) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				if (cnt_q == 3'd4) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (hdr_q[0] == BYTE_HEAD && (hdr_q[1] == CMD_STATUS || hdr_q[1] == CMD_DUMP)) begin
					state_d = ST_SEND;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SEND: begin
				push.valid = 1'b1;
				if (push_ready && last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q     <= '0;
			cnt_q        <= '0;
			k_q          <= '0;
			dump_q       <= 1'b0;
			jump_limit_q <= JUMP_LIMIT_RST;
			temp_q       <= TEMP_INVALID;
			line_q       <= ERASED;
			setp_q       <= ERASED;
			ltime_q      <= ERASED;
			ttime_q      <= ERASED;
		end else begin
			if (cfg_we) begin
				jump_limit_q <= cfg_data;
			end
			if (acc && req.opcode != OP_BYTE && !reject) begin
				temp_q <= req.sample;
			end
			if (ram_we) begin
				if (req.rx_byte == BYTE_END || wr_idx_q == AW'(FRAME_DEPTH - 1)) begin
					wr_idx_q <= '0;
				end else begin
					wr_idx_q <= wr_idx_q + 1'b1;
				end
			end
			cnt_q <= (state_q == ST_FETCH) ? cnt_q + 3'd1 : 3'd0;
			if (state_q != ST_SEND) begin
				k_q <= '0;
			end else if (push_ready) begin
				k_q <= k_q + 4'd1;
			end
			if (state_q == ST_DECODE) begin
				dump_q <= (hdr_q[1] == CMD_DUMP);
				if (hdr_q[0] == BYTE_HEAD) begin
					case (hdr_q[1])
						CMD_SETPOINT: setp_q <= word;
						CMD_LINE: begin
							line_q  <= word;
							ltime_q <= '0;
							if (word[7:0] == 8'd1) begin
								ttime_q <= '0;
							end
						end
						default: ;
					endcase
				end
			end
		end
	end

	// header bytes shift in as the store returns them
	always_ff @(posedge clk) begin
		if (state_q == ST_FETCH && cnt_q != 3'd0) begin
			hdr_q[3] <= ram_rdata;
			for (int i = 0; i < 3; i++) begin
				hdr_q[i] <= hdr_q[i+1];
			end
		end
	end

	`FCR_ASSERT_NEXT(a_end_byte_fetches, clk, arst_n, acc && req.opcode == OP_BYTE && req.rx_byte == BYTE_END, state_q == ST_FETCH, "end byte did not start a header fetch")
	`FCR_ASSERT_IMPLIES(a_index_zero_busy, clk, arst_n, state_q != ST_IDLE, wr_idx_q == '0, "write index not zero after frame end")
	`FCR_ASSERT_NEXT(a_last_beat_idle, clk, arst_n, push.valid && push_ready && push.last_byte, state_q == ST_IDLE, "sequencer busy after last beat")
	`FCR_ASSERT_IMPLIES(a_send_bounded, clk, arst_n, state_q == ST_SEND, k_q <= LAST_DUMP, "beat counter past response length")

endmodule

// ===== design/fcr_out_reg.sv =====
// output register between the sequencer and the response channel
module fcr_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  fcr_pkg::fcr_push_t push,
	output logic               push_ready,
	fcr_rsp_if.source          rsp
);
	import fcr_pkg::*;

	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;

	assign push_ready    = !valid_q || rsp.ready;
	assign rsp.valid     = valid_q;
	assign rsp.tx_byte   = byte_q;
	assign rsp.last_byte = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push.valid && push_ready) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid && push_ready) begin
			byte_q <= push.tx_byte;
			last_q <= push.last_byte;
		end
	end

endmodule

// ===== design/framed_command_responder.sv =====
// top level of the framed command responder
//
// req carries one beat per item: opcode 0 is a received serial byte, opcode 1 a
// temperature sample. rsp carries response frame bytes, last_byte marks the end.
// jump_limit is written through cfg_we/cfg_data; the user must write it only while
// the block is idle, as the block itself does not enforce it. A sample or an
// ordinary byte leaves the block idle, so req.ready stays high. The end byte 0xFE
// starts a header read from the frame store ram: four reads through its registered
// read port, then a decode state. A status command then pushes 5 beats, a dump
// command 13 beats, one per cycle while the output register can take them, into a
// single output register that drives rsp. When rsp stalls the output register
// holds its beat and the sequencer waits; req stays low until the final beat has
// entered the output register. Reset clears the write index and the output valid
// flag and resets the state registers; the header registers and the frame store
// itself are not cleared, and the store needs no clearing pass.
module framed_command_responder #(
	parameter int FRAME_DEPTH = fcr_pkg::FRAME_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	fcr_req_if.sink     req,
	fcr_rsp_if.source   rsp,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data
);
	import fcr_pkg::*;

	localparam int AW = $clog2(FRAME_DEPTH);

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;
	fcr_push_t     push;
	logic          push_ready;

	fcr_ram #(
		.WIDTH (8),
		.DEPTH (FRAME_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	fcr_seq #(
		.FRAME_DEPTH (FRAME_DEPTH)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata),
		.push       (push),
		.push_ready (push_ready)
	);

	fcr_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.rsp        (rsp)
	);

endmodule

// ===== verif/tb_framed_command_responder.sv =====
// testbench for framed_command_responder: directed table, then random frames checked by a predictor
module tb_framed_command_responder;
	import fcr_pkg::*;

	localparam int   DEPTH       = FRAME_DEPTH_DEF;
	localparam logic OP_SAMPLE   = ~OP_BYTE;
	localparam int   SETTLE      = 32;
	localparam int   IDLE_LIMIT  = 4000;
	localparam int   PHASE_ITEMS = 86;
	localparam int   N_PHASES    = 5;
	localparam int   N_DIR       = 24;

	localparam logic [103:0] NO_FRAME = '0;
	localparam logic [103:0] STATUS_AT_RESET = {BYTE_HEAD, CMD_STATUS,
		TEMP_INVALID[7:0], TEMP_INVALID[15:8], BYTE_END, 64'h0};
	localparam logic [103:0] DUMP_AT_RESET = {BYTE_HEAD, CMD_DUMP,
		{4{ERASED[7:0], ERASED[15:8]}}, TEMP_INVALID[7:0], TEMP_INVALID[15:8], BYTE_END};

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       last_byte;
	} beat_t;

	typedef struct packed {
		logic         opcode;
		logic [7:0]   rx_byte;
		logic [15:0]  sample;
		logic [3:0]   n_typed;
		logic [103:0] typed;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_data;

	fcr_req_if req ();
	fcr_rsp_if rsp ();

	framed_command_responder i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	// predictor state
	logic [7:0]  store_byte [DEPTH];
	int          store_idx;
	logic [15:0] temperature;
	logic [15:0] line_number;
	logic [15:0] setpoint;
	logic [15:0] line_time;
	logic [15:0] total_time;
	logic [15:0] jump_limit;

	beat_t tx_expect [$];
	beat_t predicted [$];
	int    fail_count;
	int    items_sent;
	int    sender_idle_pct;
	int    stall_pct;

	logic [7:0] known_cmds [4] = '{CMD_STATUS, CMD_SETPOINT, CMD_LINE, CMD_DUMP};

	dir_row_t dir_table [N_DIR] = '{
		'{OP_BYTE,   BYTE_HEAD,    16'h0000,     4'd0,  NO_FRAME},
		'{OP_BYTE,   CMD_DUMP,     16'h0000,     4'd0,  NO_FRAME},
		'{OP_BYTE,   8'h00,        16'h0000,     4'd0,  NO_FRAME},
		'{OP_BYTE,   BYTE_END,     16'h0000,     4'd13, DUMP_AT_RESET},
		'{OP_BYTE,   BYTE_HEAD,    16'h0000,     4'd0,  NO_FRAME},
		'{OP_BYTE,   CMD_STATUS,   16'h0000,     4'd0,  NO_FRAME},
		'{OP_BYTE,   BYTE_END,     16'h0000,     4'd5,  STATUS_AT_RESET},
		// most negative sample keeps the reading invalid
		'{OP_SAMPLE, 8'h00,        TEMP_INVALID, 4'd0,  NO_FRAME},
		'{OP_SAMPLE, 8'hFF,        16'h7FFF,     4'd0,  NO_FRAME},
		// step equal to the limit, then one over
		'{OP_SAMPLE, 8'h00,        16'h7FEF,     4'd0,  NO_FRAME},
		'{OP_SAMPLE, 8'h00,        16'h7FDE,     4'd0,  NO_FRAME},
		'{OP_BYTE,   BYTE_HEAD,    16'h0000,     4'd0,  NO_FRAME},
		'{OP_BYTE,   CMD_SETPOINT, 16'h0000,     4'd0,  NO_FRAME},
		'{OP_BYTE,   8'h34,        16'h0000,     4'd0,  NO_FRAME},
		'{OP_BYTE,   8'h12,        16'h0000,     4'd0,  NO_FRAME},
		'{OP_BYTE,   BYTE_END,     16'h0000,     4'd0,  NO_FRAME},
		'{OP_BYTE,   BYTE_HEAD,    16'h0000,     4'd0,  NO_FRAME},
		'{OP_BYTE,   CMD_LINE,     16'h0000,     4'd0,  NO_FRAME},
		'{OP_BYTE,   8'h01,        16'h0000,     4'd0,  NO_FRAME},
		'{OP_BYTE,   8'h00,        16'h0000,     4'd0,  NO_FRAME},
		'{OP_BYTE,   BYTE_END,     16'h0000,     4'd0,  NO_FRAME},
		// short frame, byte 2 is the end byte and byte 3 is stale
		'{OP_BYTE,   BYTE_HEAD,    16'h0000,     4'd0,  NO_FRAME},
		'{OP_BYTE,   CMD_DUMP,     16'h0000,     4'd0,  NO_FRAME},
		'{OP_BYTE,   BYTE_END,     16'h0000,     4'd0,  NO_FRAME}
	};

	initial clk = 1'b0;
	always #10 clk = ~clk;

	task automatic push_beat(input logic [7:0] b, input logic last);
		predicted.push_back(beat_t'{b, last});
	endtask

	task automatic predict_responses(input logic op, input logic [7:0] b, input logic [15:0] s);
		int          old_t;
		int          new_t;
		int          gap;
		logic [15:0] word;
		if (op == OP_SAMPLE) begin
			old_t = $signed(temperature);
			new_t = $signed(s);
			gap = (old_t > new_t) ? old_t - new_t : new_t - old_t;
			if (temperature == TEMP_INVALID || gap <= int'(jump_limit))
				temperature = s;
			return;
		end
		store_byte[store_idx] = b;
		store_idx = (store_idx + 1) % DEPTH;
		if (b != BYTE_END)
			return;
		store_idx = 0;
		if (store_byte[0] != BYTE_HEAD)
			return;
		word = {store_byte[3], store_byte[2]};
		case (store_byte[1])
			CMD_STATUS: begin
				push_beat(BYTE_HEAD, 1'b0);
				push_beat(CMD_STATUS, 1'b0);
				push_beat(temperature[7:0], 1'b0);
				push_beat(temperature[15:8], 1'b0);
				push_beat(BYTE_END, 1'b1);
			end
			CMD_SETPOINT: begin
				setpoint = word;
			end
			CMD_LINE: begin
				line_number = word;
				line_time = '0;
				if (word[7:0] == 8'h01)
					total_time = '0;
			end
			CMD_DUMP: begin
				push_beat(BYTE_HEAD, 1'b0);
				push_beat(CMD_DUMP, 1'b0);
				push_beat(line_number[7:0], 1'b0);
				push_beat(line_number[15:8], 1'b0);
				push_beat(setpoint[7:0], 1'b0);
				push_beat(setpoint[15:8], 1'b0);
				push_beat(line_time[7:0], 1'b0);
				push_beat(line_time[15:8], 1'b0);
				push_beat(total_time[7:0], 1'b0);
				push_beat(total_time[15:8], 1'b0);
				push_beat(temperature[7:0], 1'b0);
				push_beat(temperature[15:8], 1'b0);
				push_beat(BYTE_END, 1'b1);
			end
			default: begin
			end
		endcase
	endtask

	task automatic drive_item(input logic op, input logic [7:0] b, input logic [15:0] s,
			input logic [3:0] n_typed, input logic [103:0] typed);
		while ($urandom_range(99) < sender_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid   <= 1'b1;
		req.opcode  <= op;
		req.rx_byte <= b;
		req.sample  <= s;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		items_sent++;
		predicted.delete();
		predict_responses(op, b, s);
		if (n_typed != 0) begin
			for (int k = 0; k < n_typed; k++)
				tx_expect.push_back(beat_t'{typed[103 - 8 * k -: 8], k == n_typed - 1});
		end else begin
			foreach (predicted[k]) tx_expect.push_back(predicted[k]);
		end
	endtask

	task automatic send_byte(input logic [7:0] b);
		drive_item(OP_BYTE, b, 16'($urandom), 4'd0, NO_FRAME);
	endtask

	task automatic send_sample(input logic [15:0] s);
		drive_item(OP_SAMPLE, 8'($urandom), s, 4'd0, NO_FRAME);
	endtask

	function automatic logic [7:0] data_byte();
		logic [7:0] b;
		b = 8'($urandom);
		while (b == BYTE_END) b = 8'($urandom);
		return b;
	endfunction

	function automatic logic [15:0] pick_sample();
		int span;
		int delta;
		span = (int'(jump_limit) + 2 > 1000) ? 1000 : int'(jump_limit) + 2;
		delta = int'($urandom_range(2 * span)) - span;
		case ($urandom_range(9))
			0: return TEMP_INVALID;
			1, 2, 3: return 16'($urandom);
			default: return temperature + 16'(delta);
		endcase
	endfunction

	task automatic send_random_burst();
		int         kind;
		int         n;
		logic [7:0] cmd;
		kind = $urandom_range(99);
		if (kind < 15) begin
			repeat ($urandom_range(1, 3)) send_sample(pick_sample());
		end else if (kind < 40) begin
			send_byte(BYTE_HEAD);
			send_byte(CMD_STATUS);
			repeat ($urandom_range(2)) send_byte(data_byte());
			send_byte(BYTE_END);
		end else if (kind < 58) begin
			send_byte(BYTE_HEAD);
			send_byte(CMD_DUMP);
			repeat ($urandom_range(2)) send_byte(data_byte());
			send_byte(BYTE_END);
		end else if (kind < 68) begin
			send_byte(BYTE_HEAD);
			send_byte(CMD_SETPOINT);
			send_byte(data_byte());
			send_byte(data_byte());
			repeat ($urandom_range(1)) send_byte(data_byte());
			send_byte(BYTE_END);
		end else if (kind < 78) begin
			send_byte(BYTE_HEAD);
			send_byte(CMD_LINE);
			send_byte(($urandom_range(2) == 0) ? 8'h01 : data_byte());
			send_byte(data_byte());
			send_byte(BYTE_END);
		end else if (kind < 84) begin
			cmd = data_byte();
			while (cmd inside {CMD_STATUS, CMD_SETPOINT, CMD_LINE, CMD_DUMP})
				cmd = data_byte();
			send_byte(BYTE_HEAD);
			send_byte(cmd);
			send_byte(data_byte());
			send_byte(data_byte());
			send_byte(BYTE_END);
		end else if (kind < 89) begin
			n = $urandom_range(4);
			send_byte(BYTE_HEAD);
			if (n < 4)
				send_byte(known_cmds[n]);
			send_byte(BYTE_END);
		end else if (kind < 95) begin
			// the write index may wrap; the frame after it decodes only if its head byte lands at index 0
			repeat ($urandom_range(12, 20)) send_byte(data_byte());
			send_byte(BYTE_HEAD);
			send_byte(($urandom_range(1) == 0) ? CMD_STATUS : CMD_DUMP);
			send_byte(BYTE_END);
		end else begin
			repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
		end
	endtask

	// response checker and ready stalls
	initial begin
		beat_t want;
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp.valid && rsp.ready) begin
				if (tx_expect.size() == 0) begin
					$display("%0t: unexpected beat, tx_byte %h last_byte %b",
						$time, rsp.tx_byte, rsp.last_byte);
					fail_count++;
				end else begin
					want = tx_expect.pop_front();
					if (rsp.tx_byte !== want.tx_byte) begin
						$display("%0t: tx_byte expected %h, actual %h",
							$time, want.tx_byte, rsp.tx_byte);
						fail_count++;
					end
					if (rsp.last_byte !== want.last_byte) begin
						$display("%0t: last_byte expected %b, actual %b",
							$time, want.last_byte, rsp.last_byte);
						fail_count++;
					end
				end
			end
			rsp.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// watchdog on cycles with no beat on either side
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin
		logic [15:0] next_limit;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_data        = '0;
		req.valid       = 1'b0;
		req.opcode      = OP_BYTE;
		req.rx_byte     = '0;
		req.sample      = '0;
		fail_count      = 0;
		items_sent      = 0;
		sender_idle_pct = 0;
		stall_pct       = 0;
		foreach (store_byte[i]) store_byte[i] = '0;
		store_idx   = 0;
		temperature = TEMP_INVALID;
		line_number = ERASED;
		setpoint    = ERASED;
		line_time   = ERASED;
		total_time  = ERASED;
		jump_limit  = JUMP_LIMIT_RST;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_table[r])
			drive_item(dir_table[r].opcode, dir_table[r].rx_byte, dir_table[r].sample,
				dir_table[r].n_typed, dir_table[r].typed);

		for (int p = 0; p < N_PHASES; p++) begin
			req.valid <= 1'b0;
			while (tx_expect.size() != 0) @(posedge clk);
			repeat (SETTLE) @(posedge clk);
			case (p)
				0: begin
					sender_idle_pct = 0;
					stall_pct = 0;
					next_limit = 16'h0000;
				end
				1: begin
					sender_idle_pct = 83;
					stall_pct = 0;
					next_limit = 16'hFFFF;
				end
				2: begin
					sender_idle_pct = 0;
					stall_pct = 83;
					next_limit = 16'($urandom_range(1, 300));
				end
				3: begin
					sender_idle_pct = 10;
					stall_pct = 10;
					next_limit = 16'($urandom);
				end
				default: begin
					sender_idle_pct = 0;
					stall_pct = 0;
					next_limit = JUMP_LIMIT_RST;
				end
			endcase
			cfg_we   <= 1'b1;
			cfg_data <= next_limit;
			jump_limit = next_limit;
			@(posedge clk);
			cfg_we <= 1'b0;
			items_sent = 0;
			while (items_sent < PHASE_ITEMS) send_random_burst();
		end

		req.valid <= 1'b0;
		while (tx_expect.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
